>>> design/arw2_pkg.sv
// Shared widths, register codes and types for the ARW2 block decompressor.
package arw2_pkg;

    localparam int PIX_W   = 11;
    localparam int COL_W   = 14;
    localparam int ROW_W   = 14;
    localparam int CFG_W   = 15;
    localparam int BLK_W   = 128;
    localparam int IDX_W   = 4;
    localparam int OUT_W   = 40;
    localparam int DELTA_W = 7;
    localparam int HDR_BITS = 30;
    localparam int NUM_DELTAS = 16;

    localparam logic [IDX_W-1:0] LAST_IDX = 4'd15;
    localparam logic [PIX_W-1:0] PIX_MAX  = 11'h7FF;
    localparam logic [CFG_W-1:0] MAX_HEIGHT = 15'd16384;
    localparam logic [CFG_W-1:0] ROW_WIDTH_RESET = 15'd32;
    localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RESET = 15'd1;

    typedef enum logic [0:0] {
        REG_ROW_WIDTH    = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    // Start position of one block: first column (base plus odd pass) and row.
    typedef struct packed {
        logic [COL_W-1:0] col_start;
        logic [ROW_W-1:0] row;
    } scan_pos_t;

endpackage

>>> design/arw2_block_decompressor_core.sv
// Top level: block register, per-pixel decode and output register.
// Order: an accepted block request is captured in the block slot, and its pixels pass from
//   there through the output register, one per cycle when the output is taken.
// Blocks are handled one at a time by the single pixel decoder, which produces one pixel
//   per cycle from the held block when the output is taken; a new block lands on the last pixel.
// Reset (rst_n, async, active low): clears valid flags and position state,
//   row_width returns to 32 and image_height to 1.
module arw2_block_decompressor_core
    import arw2_pkg::*;
#(
    parameter int MAX_ROW_WIDTH = 16384
)
(
    input  logic             clk,
    input  logic             rst_n,
    // Block requests
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [BLK_W-1:0] s_tdata,   // block_low [63:0], block_high [127:64]
    // Pixel results
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // pixel_value [10:0], pixel_column [24:11],
                                        // pixel_row [38:25], zero pad [39]
    output logic             m_tlast,   // last_of_block
    // Configuration writes
    input  logic             cfg_we,
    input  logic [0:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    // Block slot: holds one accepted request while its pixels are walked out.
    logic             work_valid_reg;
    logic             work_valid_next;
    logic [BLK_W-1:0] blk_reg;
    logic [BLK_W-1:0] blk_next;
    scan_pos_t        start_reg;
    scan_pos_t        start_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;

    // Output register.
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [PIX_W-1:0] out_pix_reg;
    logic [PIX_W-1:0] out_pix_next;
    logic [COL_W-1:0] out_col_reg;
    logic [COL_W-1:0] out_col_next;
    logic [ROW_W-1:0] out_row_reg;
    logic [ROW_W-1:0] out_row_next;
    logic             out_last_reg;
    logic             out_last_next;

    logic             step;
    logic             work_done;
    logic             accept;
    logic [PIX_W-1:0] pix;
    scan_pos_t        cur_pos;

    // A pixel moves into the output register whenever that register is free or
    // being drained this cycle. The block slot frees up on its sixteenth pixel,
    // so a new request can land in the same cycle.
    assign step      = work_valid_reg && (!out_valid_reg || m_tready);
    assign work_done = step && (idx_reg == LAST_IDX);
    assign s_tready  = !work_valid_reg || work_done;
    assign accept    = s_tvalid && s_tready;

    arw2_scan_pos #(
        .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
    ) u_scan_pos (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (accept),
        .pos       (cur_pos)
    );

    arw2_pix_decode u_pix_decode (
        .blk (blk_reg),
        .idx (idx_reg),
        .pix (pix)
    );

    always_comb
    begin
        work_valid_next = work_valid_reg;
        blk_next        = blk_reg;
        start_next      = start_reg;
        idx_next        = idx_reg;
        if (accept)
        begin
            // Capture the block together with its position, then advance the scan.
            work_valid_next = 1'b1;
            blk_next        = s_tdata;
            start_next      = cur_pos;
            idx_next        = '0;
        end
        else if (step)
        begin
            work_valid_next = !work_done;
            idx_next        = idx_reg + IDX_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_pix_next   = out_pix_reg;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        out_last_next  = out_last_reg;
        if (step)
        begin
            // Pixels of one block sit two columns apart.
            out_valid_next = 1'b1;
            out_pix_next   = pix;
            out_col_next   = start_reg.col_start + COL_W'({idx_reg, 1'b0});
            out_row_next   = start_reg.row;
            out_last_next  = (idx_reg == LAST_IDX);
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_valid_reg <= 1'b0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            work_valid_reg <= work_valid_next;
            idx_reg        <= idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload: no reset needed.
    always_ff @(posedge clk)
    begin
        blk_reg      <= blk_next;
        start_reg    <= start_next;
        out_pix_reg  <= out_pix_next;
        out_col_reg  <= out_col_next;
        out_row_reg  <= out_row_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_row_reg, out_col_reg, out_pix_reg};
    assign m_tlast  = out_last_reg;

    // A new block may only replace a busy slot on that slot's final pixel.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && work_valid_reg) |-> (step && idx_reg == LAST_IDX))
        else $error("block slot overwritten before its last pixel");

    // The sixteenth pixel of a block carries the last flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && idx_reg == LAST_IDX) |=> (m_tvalid && m_tlast))
        else $error("last pixel of block not flagged");

    // Within a block, each pixel lands two columns past the one before.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && idx_reg != '0) |=> (out_col_reg == $past(out_col_reg) + COL_W'(2)))
        else $error("pixel column stride broken inside block");

    // A pixel is only loaded while a block is held.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !$past(m_tvalid)) |-> $past(work_valid_reg))
        else $error("pixel presented without a held block");

endmodule

>>> design/arw2_pix_decode.sv
// Decode of one pixel of a 16-byte block from the pixel index.
module arw2_pix_decode
    import arw2_pkg::*;
(
    input  logic [BLK_W-1:0] blk,
    input  logic [IDX_W-1:0] idx,
    output logic [PIX_W-1:0] pix
);

    localparam int EXT_W = HDR_BITS + DELTA_W * NUM_DELTAS;

    logic [PIX_W-1:0]   vmax;
    logic [PIX_W-1:0]   vmin;
    logic [IDX_W-1:0]   imax;
    logic [IDX_W-1:0]   imin;
    logic [PIX_W:0]     range;
    logic               range_neg;
    logic [2:0]         shift;
    logic               skip_max;
    logic               skip_min;
    logic [IDX_W-1:0]   delta_idx;
    logic [EXT_W-1:0]   blk_ext;
    logic [DELTA_W-1:0] delta [NUM_DELTAS];
    logic [PIX_W:0]     scaled;
    logic [PIX_W:0]     sum;

    assign vmax = blk[10:0];
    assign vmin = blk[21:11];
    assign imax = blk[25:22];
    assign imin = blk[29:26];

    // Signed difference; a negative range leaves the shift at zero.
    assign range     = {1'b0, vmax} - {1'b0, vmin};
    assign range_neg = range[PIX_W];
    assign shift = range_neg ? 3'd0
                 : 3'(range[10:7] != 4'd0) + 3'(range[10:8] != 3'd0)
                 + 3'(range[10:9] != 2'd0) + 3'(range[10]);

    // Deltas skip the max and min slots; both count once when they coincide.
    assign skip_max  = imax < idx;
    assign skip_min  = (imin < idx) && (imin != imax);
    assign delta_idx = idx - IDX_W'(skip_max) - IDX_W'(skip_min);

    // Delta bits past the end of the block read as zero.
    assign blk_ext = {{(EXT_W - BLK_W){1'b0}}, blk};

    always_comb
    begin
        for (int j = 0; j < NUM_DELTAS; j++)
        begin
            delta[j] = blk_ext[HDR_BITS + DELTA_W * j +: DELTA_W];
        end
    end

    assign scaled = {{(PIX_W + 1 - DELTA_W){1'b0}}, delta[delta_idx]} << shift;
    assign sum    = scaled + {1'b0, vmin};

    always_comb
    begin
        priority if (idx == imax)
        begin
            pix = vmax;
        end
        else if (idx == imin)
        begin
            pix = vmin;
        end
        else
        begin
            pix = sum[PIX_W] ? PIX_MAX : sum[PIX_W-1:0];
        end
    end

endmodule

>>> design/arw2_scan_pos.sv
// Configuration registers and column/row tracking across blocks.
module arw2_scan_pos
    import arw2_pkg::*;
#(
    parameter int MAX_ROW_WIDTH = 16384
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [0:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             advance,
    output scan_pos_t        pos
);

    localparam int CB_W  = $clog2(MAX_ROW_WIDTH);
    localparam int CMP_W = ($clog2(MAX_ROW_WIDTH) + 2 > 16) ? $clog2(MAX_ROW_WIDTH) + 2 : 16;
    localparam logic [CMP_W-1:0] WIDTH_CAP  = CMP_W'(MAX_ROW_WIDTH);
    localparam logic [CMP_W-1:0] GROUP_STEP = CMP_W'(32);
    localparam logic [CMP_W-1:0] END_MARGIN = CMP_W'(30);

    logic [CFG_W-1:0] row_width_reg;
    logic [CFG_W-1:0] row_width_next;
    logic [CFG_W-1:0] image_height_reg;
    logic [CFG_W-1:0] image_height_next;
    logic [CB_W-1:0]  column_base_reg;
    logic [CB_W-1:0]  column_base_next;
    logic             odd_pass_reg;
    logic             odd_pass_next;
    logic [ROW_W-1:0] row_count_reg;
    logic [ROW_W-1:0] row_count_next;

    logic [CMP_W-1:0] width_eff;
    logic [CMP_W-1:0] next_base;
    logic             row_end;
    logic [CFG_W-1:0] height_eff;
    logic [CFG_W-1:0] row_inc;

    assign width_eff = (CMP_W'(row_width_reg) > WIDTH_CAP) ? WIDTH_CAP
                                                           : CMP_W'(row_width_reg);
    assign next_base = CMP_W'(column_base_reg) + GROUP_STEP;
    assign row_end   = (next_base + END_MARGIN) >= width_eff;

    assign height_eff = (image_height_reg > MAX_HEIGHT) ? MAX_HEIGHT : image_height_reg;
    assign row_inc    = {1'b0, row_count_reg} + CFG_W'(1);

    always_comb
    begin
        row_width_next    = row_width_reg;
        image_height_next = image_height_reg;
        if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ROW_WIDTH:    row_width_next    = cfg_data;
                REG_IMAGE_HEIGHT: image_height_next = cfg_data;
                default:          row_width_next    = row_width_reg;
            endcase
        end
    end

    // Even pass, then odd pass, then advance the group or wrap to the next row (row zero after the last row).
    always_comb
    begin
        column_base_next = column_base_reg;
        odd_pass_next    = odd_pass_reg;
        row_count_next   = row_count_reg;
        if (advance)
        begin
            if (!odd_pass_reg)
            begin
                odd_pass_next = 1'b1;
            end
            else
            begin
                odd_pass_next = 1'b0;
                if (row_end)
                begin
                    column_base_next = '0;
                    row_count_next   = (row_inc >= height_eff) ? '0 : row_inc[ROW_W-1:0];
                end
                else
                begin
                    column_base_next = next_base[CB_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg    <= ROW_WIDTH_RESET;
            image_height_reg <= IMAGE_HEIGHT_RESET;
            column_base_reg  <= '0;
            odd_pass_reg     <= 1'b0;
            row_count_reg    <= '0;
        end
        else
        begin
            row_width_reg    <= row_width_next;
            image_height_reg <= image_height_next;
            column_base_reg  <= column_base_next;
            odd_pass_reg     <= odd_pass_next;
            row_count_reg    <= row_count_next;
        end
    end

    assign pos.col_start = COL_W'(CMP_W'(column_base_reg) + CMP_W'(odd_pass_reg));
    assign pos.row       = row_count_reg;

endmodule

>>> dv/arw2_pixel_checker.sv
// Pixel checker: predicts the decoded pixels of each block request and compares the results.
`timescale 1ns / 1ps
module arw2_pixel_checker
    import arw2_pkg::*;
#(
    parameter int MAX_ROW_WIDTH = 16384
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [BLK_W-1:0] s_tdata,    // block_low [63:0], block_high [127:64]
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [OUT_W-1:0] m_tdata,    // pixel_value [10:0], pixel_column [24:11],
                                         // pixel_row [38:25], zero pad [39]
    input  logic             m_tlast,    // last_of_block
    input  logic             cfg_we,
    input  logic [0:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    output int               pixels_owed,
    output int               mismatches
);

    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] row;
        logic             last;
    } pixel_t;

    pixel_t           pixels_due[$];
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    int               col_base;
    logic             odd_now;
    int               row_now;

    // Queue the sixteen pixels that one block decodes to at the current scan position.
    function automatic void decode_block(input logic [BLK_W-1:0] blk);
        logic [PIX_W-1:0] vmax;
        logic [PIX_W-1:0] vmin;
        logic [IDX_W-1:0] imax;
        logic [IDX_W-1:0] imin;
        logic [BLK_W-1:0] body;
        int               spread;
        int               shift;
        int               pos;
        int               value;
        pixel_t           px;
        vmax   = blk[10:0];
        vmin   = blk[21:11];
        imax   = blk[25:22];
        imin   = blk[29:26];
        spread = int'(vmax) - int'(vmin);
        shift  = 0;
        while (shift < 4 && (128 << shift) <= spread)
            shift++;
        pos = HDR_BITS;
        for (int i = 0; i < NUM_DELTAS; i++)
        begin
            if (i == imax)
                value = int'(vmax);
            else if (i == imin)
                value = int'(vmin);
            else
            begin
                // bits past the end of the block read as zero
                body  = blk >> pos;
                value = (int'(body[DELTA_W-1:0]) << shift) + int'(vmin);
                if (value > int'(PIX_MAX))
                    value = int'(PIX_MAX);
                pos += DELTA_W;
            end
            px.value  = value[PIX_W-1:0];
            px.column = COL_W'(col_base + int'(odd_now) + 2 * i);
            px.row    = ROW_W'(row_now);
            px.last   = (i == int'(LAST_IDX));
            pixels_due.push_back(px);
        end
    endfunction

    // Step to the odd pass, or to the next group, row and image.
    function automatic void advance_scan();
        int lim_w;
        int lim_h;
        if (!odd_now)
            odd_now = 1'b1;
        else
        begin
            odd_now = 1'b0;
            lim_w = (int'(width_reg) > MAX_ROW_WIDTH) ? MAX_ROW_WIDTH : int'(width_reg);
            lim_h = (height_reg > MAX_HEIGHT) ? int'(MAX_HEIGHT) : int'(height_reg);
            if (col_base + 32 + 30 >= lim_w)
            begin
                col_base = 0;
                row_now++;
                if (row_now >= lim_h)
                    row_now = 0;
            end
            else
                col_base += 32;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pixel_t want;
        pixel_t got;
        int     owed;
        if (!rst_n)
        begin
            width_reg  = ROW_WIDTH_RESET;
            height_reg = IMAGE_HEIGHT_RESET;
            col_base   = 0;
            odd_now    = 1'b0;
            row_now    = 0;
            mismatches = 0;
            pixels_due.delete();
            pixels_owed <= 0;
        end
        else
        begin
            owed = pixels_owed;
            // retire results before queueing new ones
            if (m_tvalid && m_tready)
            begin
                got.value  = m_tdata[PIX_W-1:0];
                got.column = m_tdata[PIX_W +: COL_W];
                got.row    = m_tdata[PIX_W+COL_W +: ROW_W];
                got.last   = m_tlast;
                if (pixels_due.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected pixel: value %0d col %0d row %0d last %0b",
                                 got.value, got.column, got.row, got.last);
                    mismatches++;
                end
                else
                begin
                    want = pixels_due.pop_front();
                    owed--;
                    if (got != want)
                    begin
                        if (mismatches < 10)
                            $display({"pixel mismatch: expected value %0d col %0d row %0d",
                                      " last %0b, got value %0d col %0d row %0d last %0b"},
                                     want.value, want.column, want.row, want.last,
                                     got.value, got.column, got.row, got.last);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                decode_block(s_tdata);
                advance_scan();
                owed += NUM_DELTAS;
            end
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_ROW_WIDTH:    width_reg  = cfg_data;
                    REG_IMAGE_HEIGHT: height_reg = cfg_data;
                    default: ;
                endcase
            end
            pixels_owed <= owed;
        end
    end

endmodule

>>> dv/arw2_block_decompressor_core_test.sv
// Testbench top: drives block requests and register writes, stalls results, gives the verdict.
`timescale 1ns / 1ps
module arw2_block_decompressor_core_test;
    import arw2_pkg::*;

    localparam int ROW_LIMIT   = 16384;
    localparam int QUIET_LIMIT = 4000;   // cycles with no request or result moving
    localparam int HOLD_CYCLES = 300;    // long receiver hold-off that backs up the block

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [BLK_W-1:0] s_tdata   = '0;
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic             m_tlast;
    logic             cfg_we    = 1'b0;
    logic [0:0]       cfg_index = '0;
    logic [CFG_W-1:0] cfg_data  = '0;

    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic hold_off       = 1'b0;
    int   quiet_cycles   = 0;
    int   pixels_owed;
    int   mismatches;

    arw2_block_decompressor_core #(
        .MAX_ROW_WIDTH(ROW_LIMIT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    arw2_pixel_checker #(
        .MAX_ROW_WIDTH(ROW_LIMIT)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .pixels_owed(pixels_owed),
        .mismatches(mismatches)
    );

    always #6 clk = ~clk;

    // Receiver: stall at the phase's rate, and hold off entirely while hold_off is set.
    always @(posedge clk)
        m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);

    // Watchdog: end the run if nothing moves on either channel for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Build a block from a body of delta bits and a given header.
    function automatic logic [BLK_W-1:0] make_block(input logic [BLK_W-1:0] body,
                                                    input logic [PIX_W-1:0] vmax,
                                                    input logic [PIX_W-1:0] vmin,
                                                    input logic [IDX_W-1:0] imax,
                                                    input logic [IDX_W-1:0] imin);
        return {body[BLK_W-1:HDR_BITS], imin, imax, vmin, vmax};
    endfunction

    function automatic logic [BLK_W-1:0] random_bits();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // Mostly headers with max at or above min over every shift range, the rest raw noise.
    function automatic logic [BLK_W-1:0] random_block();
        logic [BLK_W-1:0] blk;
        logic [PIX_W-1:0] floor_v;
        int               spread;
        blk = random_bits();
        if ($urandom_range(3) != 0)
        begin
            floor_v = PIX_W'($urandom_range(2047));
            spread  = $urandom_range(2047) >> $urandom_range(5);
            if (int'(floor_v) + spread > 2047)
                spread = 2047 - int'(floor_v);
            blk[10:0]  = PIX_W'(int'(floor_v) + spread);
            blk[21:11] = floor_v;
            // shared position for max and min now and then
            if ($urandom_range(7) == 0)
                blk[29:26] = blk[25:22];
        end
        return blk;
    endfunction

    // Offer one block request after a random idle gap; return at the accepting edge.
    task automatic send_block(input logic [BLK_W-1:0] blk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= blk;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Wait until every expected pixel is out, then let the pipeline settle.
    task automatic drain();
        @(posedge clk);
        while (pixels_owed != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write both registers on consecutive edges; hold the enable across them.
    task automatic set_geometry(input logic [CFG_W-1:0] width,
                                input logic [CFG_W-1:0] height);
        cfg_we    <= 1'b1;
        cfg_index <= REG_ROW_WIDTH;
        cfg_data  <= width;
        @(posedge clk);
        cfg_index <= REG_IMAGE_HEIGHT;
        cfg_data  <= height;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // One phase: reconfigure while idle, set the idle rates, stream random blocks.
    task automatic run_phase(input logic [CFG_W-1:0] width, input logic [CFG_W-1:0] height,
                             input int idle_pct, input int stall_pct, input int blocks,
                             input bit hold);
        drain();
        set_geometry(width, height);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        if (hold)
        begin
            fork
                begin
                    hold_off <= 1'b1;
                    repeat (HOLD_CYCLES) @(posedge clk);
                    hold_off <= 1'b0;
                end
            join_none
        end
        repeat (blocks) send_block(random_block());
        s_tvalid <= 1'b0;
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed blocks at the reset geometry, no idling.
        send_block('0);
        send_block('1);
        send_block(make_block(random_bits(), 11'h7FF, 11'h000, 4'd0, 4'd15));
        // shift thresholds: range just below and at the first two steps, at the last two
        send_block(make_block(random_bits(), 11'h17F, 11'h100, 4'd3, 4'd4));
        send_block(make_block(random_bits(), 11'h180, 11'h100, 4'd3, 4'd4));
        send_block(make_block(random_bits(), 11'h1FF, 11'h100, 4'd5, 4'd1));
        send_block(make_block(random_bits(), 11'h200, 11'h100, 4'd5, 4'd1));
        send_block(make_block(random_bits(), 11'h300, 11'h100, 4'd8, 4'd2));
        send_block(make_block(random_bits(), 11'h500, 11'h100, 4'd8, 4'd2));
        // min above max: no shift, deltas on a high min clamp
        send_block(make_block('1, 11'h000, 11'h7F0, 4'd5, 4'd6));
        send_block(make_block(random_bits(), 11'h100, 11'h7FF, 4'd12, 4'd11));
        // max and min at the same position, then at the two ends
        send_block(make_block(random_bits(), 11'h600, 11'h010, 4'd0, 4'd0));
        send_block(make_block('1, 11'h600, 11'h010, 4'd15, 4'd15));
        send_block(make_block(random_bits(), 11'h7FF, 11'h000, 4'd9, 4'd9));
        send_block(make_block(random_bits(), 11'h345, 11'h012, 4'd0, 4'd15));
        // full deltas at shift 4: lands on the top value, then one over it
        send_block(make_block('1, 11'h7FF, 11'h00F, 4'd1, 4'd2));
        send_block(make_block('1, 11'h7FF, 11'h010, 4'd1, 4'd2));
        repeat (6) send_block(random_block());
        s_tvalid <= 1'b0;

        run_phase(15'd64,    15'd3,     0,  0,  50, 1'b0);
        run_phase(15'd96,    15'd2,     88, 0,  40, 1'b0);
        run_phase(15'd32,    15'd0,     0,  88, 40, 1'b1);
        run_phase(15'd50,    15'd16384, 14, 14, 40, 1'b0);
        run_phase(15'd0,     15'd32767, 0,  0,  30, 1'b0);
        run_phase(15'd16384, 15'd5,     88, 0,  30, 1'b0);
        run_phase(15'd32767, 15'd1,     0,  88, 30, 1'b0);

        drain();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pixels_owed == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> arw2_block_decompressor_core.f
design/arw2_pkg.sv
design/arw2_pix_decode.sv
design/arw2_scan_pos.sv
design/arw2_block_decompressor_core.sv
dv/arw2_pixel_checker.sv
dv/arw2_block_decompressor_core_test.sv
